[src/ted_pkg.sv]
// shared types, constants and byte class functions of the text encoding detector
package ted_pkg;

   // byte values that the checks use
   localparam logic [7:0] BomByte0     = 8'hEF;
   localparam logic [7:0] BomByte1     = 8'hBB;
   localparam logic [7:0] BomByte2     = 8'hBF;
   localparam logic [7:0] AsciiLimit   = 8'h80;
   localparam logic [2:0] Lead2Pattern = 3'h6;   // 110xxxxx
   localparam logic [3:0] Lead3Pattern = 4'hE;   // 1110xxxx
   localparam logic [4:0] Lead4Pattern = 5'h1E;  // 11110xxx
   localparam logic [1:0] ContPattern  = 2'h2;   // 10xxxxxx
   localparam logic [7:0] SjisLeadLo1  = 8'h81;
   localparam logic [7:0] SjisLeadHi1  = 8'h9F;
   localparam logic [7:0] SjisLeadLo2  = 8'hE0;
   localparam logic [7:0] SjisLeadHi2  = 8'hFC;
   localparam logic [7:0] SjisTrailLo1 = 8'h40;
   localparam logic [7:0] SjisTrailHi1 = 8'h7E;
   localparam logic [7:0] SjisTrailLo2 = 8'h80;
   localparam logic [7:0] SjisTrailHi2 = 8'hFC;
   localparam logic [1:0] BomLength    = 2'd3;

   // result codes
   typedef enum logic [2:0] {
      EncUnknown  = 3'd0,
      EncAscii    = 3'd1,
      EncUtf8     = 3'd2,
      EncUtf8Bom  = 3'd3,
      EncShiftJis = 3'd4
   } encoding_type;

   // one input item as held in the input register
   typedef struct packed {
      logic       valid;
      logic [7:0] byte_value;
      logic       has_byte;
      logic       is_last;
   } step_type;

   // running state of one stream
   typedef struct packed {
      logic [1:0] position_count;
      logic       bom_match;
      logic       all_ascii;
      logic [1:0] continuations_due;
      logic       utf8_bad;
      logic [7:0] previous_byte;
      logic       previous_present;
      logic       sjis_seen;
   } scan_state_type;

   localparam scan_state_type ScanInit = '{
      position_count:    2'd0,
      bom_match:         1'b1,
      all_ascii:         1'b1,
      continuations_due: 2'd0,
      utf8_bad:          1'b0,
      previous_byte:     8'h00,
      previous_present:  1'b0,
      sjis_seen:         1'b0
   };

   // result fields of one stream
   typedef struct packed {
      encoding_type encoding_code;
      logic         ascii_flag;
      logic         utf8_ok;
      logic         sjis_pair_found;
   } result_type;

   function automatic logic is_sjis_lead(input logic [7:0] b);
      return ((b >= SjisLeadLo1) && (b <= SjisLeadHi1)) ||
             ((b >= SjisLeadLo2) && (b <= SjisLeadHi2));
   endfunction

   function automatic logic is_sjis_trail(input logic [7:0] b);
      return ((b >= SjisTrailLo1) && (b <= SjisTrailHi1)) ||
             ((b >= SjisTrailLo2) && (b <= SjisTrailHi2));
   endfunction

   function automatic logic [7:0] bom_byte(input logic [1:0] idx);
      logic [7:0] r;
      unique case (idx)
         2'd0:    r = BomByte0;
         2'd1:    r = BomByte1;
         default: r = BomByte2;
      endcase
      return r;
   endfunction

endpackage

[src/ted_if.sv]
// valid/ready channels for input bytes and classification results
interface ted_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       has_byte;
   logic       is_last;

   modport source (output valid, byte_value, has_byte, is_last, input ready);
   modport sink   (input valid, byte_value, has_byte, is_last, output ready);
endinterface

interface ted_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] encoding_code;
   logic       ascii_flag;
   logic       utf8_ok;
   logic       sjis_pair_found;

   modport source (output valid, encoding_code, ascii_flag, utf8_ok, sjis_pair_found,
                   input ready);
   modport sink   (input valid, encoding_code, ascii_flag, utf8_ok, sjis_pair_found,
                   output ready);
endinterface

[src/ted_scan.sv]
// running stream state: bom match, ascii, utf-8 structure and shift-jis pair tracking
module ted_scan import ted_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  step_type       step,
   input  logic           advance,
   output scan_state_type view
);

   scan_state_type state_ff;
   scan_state_type state_in;
   scan_state_type upd;
   logic           take;

   // state after the byte held in the input register
   always_comb begin
      upd = state_ff;
      // bom prefix and byte count
      if (state_ff.position_count < BomLength) begin
         if (step.byte_value != bom_byte(state_ff.position_count)) begin
            upd.bom_match = 1'b0;
         end
         upd.position_count = state_ff.position_count + 2'd1;
      end
      if (step.byte_value >= AsciiLimit) begin
         upd.all_ascii = 1'b0;
      end
      // lenient utf-8 structure
      if (!state_ff.utf8_bad) begin
         priority if (state_ff.continuations_due != 2'd0) begin
            if (step.byte_value[7:6] == ContPattern) begin
               upd.continuations_due = state_ff.continuations_due - 2'd1;
            end else begin
               upd.utf8_bad = 1'b1;
            end
         end else if (step.byte_value < AsciiLimit) begin
            upd.continuations_due = 2'd0;
         end else if (step.byte_value[7:5] == Lead2Pattern) begin
            upd.continuations_due = 2'd1;
         end else if (step.byte_value[7:4] == Lead3Pattern) begin
            upd.continuations_due = 2'd2;
         end else if (step.byte_value[7:3] == Lead4Pattern) begin
            upd.continuations_due = 2'd3;
         end else begin
            upd.utf8_bad = 1'b1;
         end
      end
      // shift-jis lead/trail pair
      if (state_ff.previous_present && is_sjis_lead(state_ff.previous_byte) &&
          is_sjis_trail(step.byte_value)) begin
         upd.sjis_seen = 1'b1;
      end
      upd.previous_byte    = step.byte_value;
      upd.previous_present = 1'b1;
   end

   assign view = step.has_byte ? upd : state_ff;
   assign take = step.valid && advance;

   // next state: clear at end of stream, otherwise fold in the byte
   always_comb begin
      state_in = state_ff;
      if (take) begin
         if (step.is_last) begin
            state_in = ScanInit;
         end else if (step.has_byte) begin
            state_in = upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ScanInit;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   // the state is back to its start value after an end of stream
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (take && step.is_last) |=> (state_ff == ScanInit))
      else $error("scan state not cleared after end of stream");

   // byte count and previous byte presence move together
   a_count_matches_prev: assert property (@(posedge clock) disable iff (reset)
      (state_ff.position_count == 2'd0) == !state_ff.previous_present)
      else $error("byte count and previous byte disagree");

   // a pending continuation means a byte of 0x80 or above was seen
   a_cont_not_ascii: assert property (@(posedge clock) disable iff (reset)
      (state_ff.continuations_due != 2'd0) |-> !state_ff.all_ascii)
      else $error("continuation pending on an all-ascii stream");
`endif

endmodule

[src/ted_classify.sv]
// final classification of a stream from its running state
module ted_classify import ted_pkg::*; (
   input  scan_state_type view,
   output result_type     result
);

   logic utf8_good;

   assign utf8_good = !view.utf8_bad && (view.continuations_due == 2'd0);

   // tests in order: empty, bom, ascii, utf-8, otherwise shift-jis
   always_comb begin
      priority if (view.position_count == 2'd0) begin
         result.encoding_code = EncUnknown;
      end else if ((view.position_count == BomLength) && view.bom_match) begin
         result.encoding_code = EncUtf8Bom;
      end else if (view.all_ascii) begin
         result.encoding_code = EncAscii;
      end else if (utf8_good) begin
         result.encoding_code = EncUtf8;
      end else begin
         result.encoding_code = EncShiftJis;
      end
      result.ascii_flag      = view.all_ascii;
      result.utf8_ok         = utf8_good;
      result.sjis_pair_found = view.sjis_seen;
   end

endmodule

[src/text_encoding_detector_core.sv]
// text encoding detector: input register, stream scan, classification, result register
//
//   channel   dir   handshake          payload
//   req_chan  in    valid/ready        byte_value[7:0], has_byte, is_last
//   rsp_chan  out   valid/ready        encoding_code[2:0], ascii_flag, utf8_ok, sjis_pair_found
//
// one item per cycle save the stall below; a result is registered as its last item moves on.
// the running state update of one byte, held in the input register, sets the cycle.
// reset is synchronous and clears the input stage, the stream state and the result valid.
// only an item that ends a stream waits on a full result register; other items pass.
module text_encoding_detector_core import ted_pkg::*; (
   input logic       clock,
   input logic       reset,
   ted_req_if.sink   req_chan,
   ted_rsp_if.source rsp_chan
);

   step_type       in_ff;
   step_type       in_in;
   logic           advance;
   scan_state_type view;
   result_type     result;
   result_type     rsp_data_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           fire_last;

   // the held item moves on unless it ends a stream and the result slot is blocked
   assign advance   = !in_ff.valid || !in_ff.is_last || !rsp_valid_ff || rsp_chan.ready;
   assign fire_last = in_ff.valid && in_ff.is_last && advance;
   assign req_chan.ready = advance;

   // input register
   always_comb begin
      in_in = in_ff;
      if (advance) begin
         in_in.valid      = req_chan.valid;
         in_in.byte_value = req_chan.byte_value;
         in_in.has_byte   = req_chan.has_byte;
         in_in.is_last    = req_chan.is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid <= 1'b0;
      end else begin
         in_ff.valid <= in_in.valid;
      end
      in_ff.byte_value <= in_in.byte_value;
      in_ff.has_byte   <= in_in.has_byte;
      in_ff.is_last    <= in_in.is_last;
   end

   ted_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .step    (in_ff),
      .advance (advance),
      .view    (view)
   );

   ted_classify u_classify (
      .view   (view),
      .result (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire_last) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.encoding_code   = rsp_data_ff.encoding_code;
   assign rsp_chan.ascii_flag      = rsp_data_ff.ascii_flag;
   assign rsp_chan.utf8_ok         = rsp_data_ff.utf8_ok;
   assign rsp_chan.sjis_pair_found = rsp_data_ff.sjis_pair_found;

`ifndef SYNTH
   // a result only follows an end-of-stream item leaving the input register
   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_ff.valid && in_ff.is_last))
      else $error("result without end of stream");

   // a blocked result holds back a waiting end-of-stream item
   a_stall_holds_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready && in_ff.valid && in_ff.is_last) |-> !req_chan.ready)
      else $error("end-of-stream item overran a pending result");

   // an unknown result only comes from an empty stream
   a_unknown_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.encoding_code == EncUnknown)) |->
      (rsp_data_ff.ascii_flag && rsp_data_ff.utf8_ok && !rsp_data_ff.sjis_pair_found))
      else $error("unknown code on a non-empty stream");
`endif

endmodule

[dv/text_encoding_detector_core_tb.sv]
// testbench of the text encoding detector: byte streams in, classification results checked
module text_encoding_detector_core_tb import ted_pkg::*;;

   localparam int RandomItems = 650;
   localparam int HoldCycles  = 400;
   localparam int DrainCycles = 8;

   // scoreboard: running scan of the open stream and the queue of expected classifications
   class encoding_scoreboard;
      bit [1:0]   bytes_seen;
      bit         bom_prefix;
      bit         only_ascii;
      bit [1:0]   conts_owed;
      bit         utf8_broken;
      bit [7:0]   last_byte;
      bit         last_byte_valid;
      bit         sjis_hit;
      result_type expected_q[$];
      int         error_count;
      int         checked_count;
      int         code_tally[5];

      function new();
         error_count   = 0;
         checked_count = 0;
         foreach (code_tally[i]) code_tally[i] = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         bytes_seen      = 2'd0;
         bom_prefix      = 1'b1;
         only_ascii      = 1'b1;
         conts_owed      = 2'd0;
         utf8_broken     = 1'b0;
         last_byte       = 8'h00;
         last_byte_valid = 1'b0;
         sjis_hit        = 1'b0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // shift-jis lead and trail byte ranges
      function bit sjis_lead(bit [7:0] b);
         return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
      endfunction

      function bit sjis_trail(bit [7:0] b);
         return (b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC);
      endfunction

      // fold one accepted item into the scan; a stream end queues its classification
      function void note_item(bit [7:0] b, bit has, bit last);
         bit [7:0]   want;
         bit         utf8_good;
         result_type exp;
         if (has) begin
            // bom prefix over the first three bytes
            if (bytes_seen != 2'd3) begin
               case (bytes_seen)
                  2'd0:    want = BomByte0;
                  2'd1:    want = BomByte1;
                  default: want = BomByte2;
               endcase
               if (b != want) bom_prefix = 1'b0;
               bytes_seen++;
            end
            if (b[7]) only_ascii = 1'b0;
            // lenient utf-8 structure
            if (!utf8_broken) begin
               if (conts_owed != 2'd0) begin
                  if (b[7:6] == 2'b10) conts_owed--;
                  else utf8_broken = 1'b1;
               end else if (b[7]) begin
                  if (b[7:5] == 3'b110)        conts_owed = 2'd1;
                  else if (b[7:4] == 4'b1110)  conts_owed = 2'd2;
                  else if (b[7:3] == 5'b11110) conts_owed = 2'd3;
                  else                         utf8_broken = 1'b1;
               end
            end
            // adjacent shift-jis pair
            if (last_byte_valid && sjis_lead(last_byte) && sjis_trail(b)) sjis_hit = 1'b1;
            last_byte       = b;
            last_byte_valid = 1'b1;
         end
         if (last) begin
            utf8_good = !utf8_broken && (conts_owed == 2'd0);
            if (bytes_seen == 2'd0)                    exp.encoding_code = EncUnknown;
            else if (bytes_seen == 2'd3 && bom_prefix) exp.encoding_code = EncUtf8Bom;
            else if (only_ascii)                       exp.encoding_code = EncAscii;
            else if (utf8_good)                        exp.encoding_code = EncUtf8;
            else                                       exp.encoding_code = EncShiftJis;
            exp.ascii_flag      = only_ascii;
            exp.utf8_ok         = utf8_good;
            exp.sjis_pair_found = sjis_hit;
            expected_q = {expected_q, exp};
            clear_scan();
         end
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         error_count++;
      endtask

      // compare one accepted result with the oldest expectation
      task check_result(result_type got);
         result_type exp;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result with no stream pending (code %0d)",
                                      got.encoding_code));
         end else begin
            exp = expected_q.pop_front();
            code_tally[exp.encoding_code]++;
            if (got.encoding_code !== exp.encoding_code)
               report_mismatch($sformatf("result %0d encoding_code: got %0d, expected %0d",
                                         checked_count, got.encoding_code,
                                         exp.encoding_code));
            if (got.ascii_flag !== exp.ascii_flag)
               report_mismatch($sformatf("result %0d ascii_flag: got %0b, expected %0b",
                                         checked_count, got.ascii_flag, exp.ascii_flag));
            if (got.utf8_ok !== exp.utf8_ok)
               report_mismatch($sformatf("result %0d utf8_ok: got %0b, expected %0b",
                                         checked_count, got.utf8_ok, exp.utf8_ok));
            if (got.sjis_pair_found !== exp.sjis_pair_found)
               report_mismatch($sformatf("result %0d sjis_pair_found: got %0b, expected %0b",
                                         checked_count, got.sjis_pair_found,
                                         exp.sjis_pair_found));
         end
         checked_count++;
      endtask
   endclass

   logic clock;
   logic reset;
   bit   steady;
   int   items_sent;
   logic [7:0] stream_bytes[$];

   encoding_scoreboard sb = new();

   ted_req_if req_chan ();
   ted_rsp_if rsp_chan ();

   text_encoding_detector_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("timeout waiting for the block");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // idle lengths: mostly short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int pick_stall();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one item and wait until the block takes it
   task automatic send_item(input logic [7:0] b, input logic has, input logic last);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.byte_value <= b;
      req_chan.has_byte   <= has;
      req_chan.is_last    <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_item(b, has, last);
      if (has || last) items_sent++;
   endtask

   // send the bytes in stream_bytes as one stream, optionally with idle items mixed in
   task automatic send_stream(input bit separate_last, input bit with_idles);
      int n;
      n = stream_bytes.size();
      for (int i = 0; i < n; i++) begin
         if (with_idles && $urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(stream_bytes[i], 1'b1, (i == n - 1) && !separate_last);
      end
      if (n == 0 || separate_last) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // stream buffer: add a byte at the end, drop the byte at the end
   function automatic void append_byte(logic [7:0] b);
      stream_bytes = {stream_bytes, b};
   endfunction

   function automatic void drop_byte();
      if (stream_bytes.size() != 0) stream_bytes.delete(stream_bytes.size() - 1);
   endfunction

   // stream content builders
   function automatic logic [7:0] cont_byte();
      logic [7:0] r;
      r = 8'($urandom);
      return {2'b10, r[5:0]};
   endfunction

   function automatic void add_utf8_char(int n);
      logic [7:0] r;
      r = 8'($urandom);
      case (n)
         1: append_byte({1'b0, r[6:0]});
         2: append_byte({3'b110, r[4:0]});
         3: append_byte({4'b1110, r[3:0]});
         default: append_byte({5'b11110, r[2:0]});
      endcase
      for (int i = 1; i < n; i++) append_byte(cont_byte());
   endfunction

   function automatic void add_sjis_char();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) begin
         append_byte(8'($urandom_range(0, 1) ? $urandom_range(8'h81, 8'h9F)
                                             : $urandom_range(8'hE0, 8'hFC)));
         append_byte(8'($urandom_range(0, 1) ? $urandom_range(8'h40, 8'h7E)
                                             : $urandom_range(8'h80, 8'hFC)));
      end else if (r < 8) begin
         append_byte(8'($urandom_range(8'h20, 8'h7F)));
      end else begin
         // half-width kana
         append_byte(8'($urandom_range(8'hA1, 8'hDF)));
      end
   endfunction

   // one random stream of a random kind
   task automatic random_stream();
      int kind;
      int chars;
      int idx;
      kind  = $urandom_range(0, 99);
      chars = $urandom_range(1, 6);
      stream_bytes = {};
      if (kind < 30) begin
         // well-formed utf-8
         repeat (chars) add_utf8_char($urandom_range(1, 4));
      end else if (kind < 40) begin
         // bom then utf-8
         stream_bytes = '{BomByte0, BomByte1, BomByte2};
         repeat ($urandom_range(0, 4)) add_utf8_char($urandom_range(1, 4));
      end else if (kind < 52) begin
         // ascii text
         repeat (chars) add_utf8_char(1);
      end else if (kind < 67) begin
         // shift-jis text
         repeat (chars) add_sjis_char();
      end else if (kind < 79) begin
         // broken utf-8: cut off, damaged byte or stray lead
         repeat (chars) add_utf8_char($urandom_range(1, 4));
         case ($urandom_range(0, 2))
            0: drop_byte();
            1: begin
               idx = $urandom_range(0, stream_bytes.size() - 1);
               stream_bytes[idx] = 8'($urandom);
            end
            default: append_byte({4'b1110, 4'($urandom)});
         endcase
      end else if (kind < 89) begin
         // raw noise
         repeat ($urandom_range(1, 10)) append_byte(8'($urandom));
      end else if (kind < 95) begin
         // bom prefixes, whole or partial, sometimes with a wrong byte
         stream_bytes = '{BomByte0, BomByte1, BomByte2};
         repeat ($urandom_range(0, 2)) drop_byte();
         if ($urandom_range(0, 2) == 0)
            stream_bytes[stream_bytes.size() - 1] = 8'($urandom);
      end
      // the rest stay empty
      send_stream($urandom_range(0, 3) == 0, !steady);
   endtask

   // result side: check accepted results, random stalls and one long hold
   initial begin : result_sink
      int         stall_left;
      int         hold_left;
      bit         hold_done;
      logic       next_ready;
      result_type got;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.encoding_code   = encoding_type'(rsp_chan.encoding_code);
            got.ascii_flag      = rsp_chan.ascii_flag;
            got.utf8_ok         = rsp_chan.utf8_ok;
            got.sjis_pair_found = rsp_chan.sjis_pair_found;
            sb.check_result(got);
         end
         // long hold once traffic is under way, so the block backs up
         if (!hold_done && sb.checked_count >= 15) begin
            hold_left = HoldCycles;
            hold_done = 1'b1;
         end
         next_ready = 1'b1;
         if (reset) begin
            next_ready = 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else if (!steady && $urandom_range(0, 99) < 15) begin
            stall_left = pick_stall() - 1;
            next_ready = 1'b0;
         end
         rsp_chan.ready <= next_ready;
      end
   end

   // stimulus
   initial begin
      int streams;
      steady     = 1'b0;
      items_sent = 0;
      streams    = 0;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.byte_value <= 8'h00;
      req_chan.has_byte   <= 1'b0;
      req_chan.is_last    <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty stream
      stream_bytes = {};
      send_stream(1'b0, 1'b0);
      // full bom, alone and followed by text
      stream_bytes = '{8'hEF, 8'hBB, 8'hBF};
      send_stream(1'b0, 1'b0);
      stream_bytes = '{8'hEF, 8'hBB, 8'hBF, 8'h41};
      send_stream(1'b1, 1'b0);
      // two bytes of a bom are not a bom
      stream_bytes = '{8'hEF, 8'hBB};
      send_stream(1'b0, 1'b0);
      // ascii extremes
      stream_bytes = '{8'h00, 8'h7F};
      send_stream(1'b0, 1'b0);
      // two and four byte utf-8
      stream_bytes = '{8'hC3, 8'hA9};
      send_stream(1'b0, 1'b0);
      stream_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80};
      send_stream(1'b1, 1'b0);
      // shift-jis pair
      stream_bytes = '{8'h82, 8'hA0};
      send_stream(1'b0, 1'b0);
      // top byte value
      stream_bytes = '{8'hFF};
      send_stream(1'b0, 1'b0);
      // utf-8 sequence cut off at the end
      stream_bytes = '{8'hE3, 8'h81};
      send_stream(1'b0, 1'b0);
      // idle item inside a stream, end marked without a byte
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'h5A, 1'b0, 1'b1);

      // random streams, with one stretch free of idling
      while (items_sent < RandomItems + 25) begin
         steady = (streams >= 20) && (streams < 36);
         random_stream();
         streams++;
      end
      steady = 1'b0;
      req_chan.valid <= 1'b0;

      // drain
      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("%0d items in %0d random streams plus directed cases, %0d results checked",
               items_sent, streams, sb.checked_count);
      $display("codes seen: unknown %0d, ascii %0d, utf-8 %0d, utf-8 bom %0d, shift-jis %0d",
               sb.code_tally[EncUnknown], sb.code_tally[EncAscii], sb.code_tally[EncUtf8],
               sb.code_tally[EncUtf8Bom], sb.code_tally[EncShiftJis]);
      if (sb.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[text_encoding_detector_core.f]
src/ted_pkg.sv
src/ted_if.sv
src/ted_scan.sv
src/ted_classify.sv
src/text_encoding_detector_core.sv
dv/text_encoding_detector_core_tb.sv
